@@ hw/rtl/tres_pkg.sv @@
// ----------------------------------------------------------------------------
// tres_pkg: shared types and microcode for the text record exchange sorter
// Control word layout, step codes, sort modes and the sequencer program ROM.
// ----------------------------------------------------------------------------
package tres_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned TEXT_W = 4 * WORD_W;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned RANK_W = 7;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned UPC_W  = 4;

  typedef logic [UPC_W-1:0] upc_t;

  // Sort modes
  localparam logic [MODE_W-1:0] SO_NAME_DESC  = 2'd0;
  localparam logic [MODE_W-1:0] SO_NAME_ASC   = 2'd1;
  localparam logic [MODE_W-1:0] SO_GRADE_ASC  = 2'd2;
  localparam logic [MODE_W-1:0] SO_GRADE_DESC = 2'd3;
  localparam logic [MODE_W-1:0] SO_RESET      = SO_NAME_ASC;

  // Program steps
  localparam upc_t U_LOAD  = 4'd0;   // take records
  localparam upc_t U_AINIT = 4'd1;   // a = 0
  localparam upc_t U_ARD   = 4'd2;   // read order[a], b = a + 1
  localparam upc_t U_AREC  = 4'd3;   // cur = order[a], read its record
  localparam upc_t U_LATA  = 4'd4;   // hold record of cur, read order[b]
  localparam upc_t U_BREC  = 4'd5;   // read record of order[b]
  localparam upc_t U_CMP   = 4'd6;   // compare, swap, b++
  localparam upc_t U_BRD   = 4'd7;   // read order[b]
  localparam upc_t U_WB    = 4'd8;   // order[a] = cur, a++
  localparam upc_t U_OINIT = 4'd9;   // k = 0
  localparam upc_t U_ORD   = 4'd10;  // read order[k or n-1-k]
  localparam upc_t U_OREC  = 4'd11;  // read record
  localparam upc_t U_OLD   = 4'd12;  // load output register
  localparam upc_t U_ONXT  = 4'd13;  // k++

  typedef enum logic [2:0] {
    C_NEXT,   // fall through
    C_GOTO,   // jump
    C_IN,     // hold until a transaction with the last flag, then jump
    C_AEND,   // jump when a is the last index
    C_BEND,   // jump when b is the last index
    C_OUT     // hold until the output loads; jump on the last rank
  } cond_e;

  typedef enum logic [1:0] {
    OS_A,
    OS_B,
    OS_K
  } ord_sel_e;

  typedef struct packed {
    logic     in_rdy;
    logic     ord_re;
    ord_sel_e ord_sel;
    logic     rec_re;
    logic     cur_ld;
    logic     lat_a;
    logic     a_clr;
    logic     b_init;
    logic     cmp;
    logic     wb;
    logic     k_clr;
    logic     k_inc;
    logic     out_ld;
    cond_e    cond;
    upc_t     target;
  } ctrl_t;

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    w        = '0;
    w.cond   = C_GOTO;
    w.target = U_LOAD;
    w.ord_sel = OS_A;
    unique case (pc)
      U_LOAD: begin
        w.in_rdy = 1'b1;
        w.cond   = C_IN;
        w.target = U_AINIT;
      end
      U_AINIT: begin
        w.a_clr = 1'b1;
        w.cond  = C_NEXT;
      end
      U_ARD: begin
        w.ord_re  = 1'b1;
        w.ord_sel = OS_A;
        w.b_init  = 1'b1;
        w.cond    = C_AEND;
        w.target  = U_OINIT;
      end
      U_AREC: begin
        w.rec_re = 1'b1;
        w.cur_ld = 1'b1;
        w.cond   = C_NEXT;
      end
      U_LATA: begin
        w.lat_a   = 1'b1;
        w.ord_re  = 1'b1;
        w.ord_sel = OS_B;
        w.cond    = C_NEXT;
      end
      U_BREC: begin
        w.rec_re = 1'b1;
        w.cond   = C_NEXT;
      end
      U_CMP: begin
        w.cmp    = 1'b1;
        w.cond   = C_BEND;
        w.target = U_WB;
      end
      U_BRD: begin
        w.ord_re  = 1'b1;
        w.ord_sel = OS_B;
        w.cond    = C_GOTO;
        w.target  = U_BREC;
      end
      U_WB: begin
        w.wb     = 1'b1;
        w.cond   = C_GOTO;
        w.target = U_ARD;
      end
      U_OINIT: begin
        w.k_clr = 1'b1;
        w.cond  = C_NEXT;
      end
      U_ORD: begin
        w.ord_re  = 1'b1;
        w.ord_sel = OS_K;
        w.cond    = C_NEXT;
      end
      U_OREC: begin
        w.rec_re = 1'b1;
        w.cond   = C_NEXT;
      end
      U_OLD: begin
        w.out_ld = 1'b1;
        w.cond   = C_OUT;
        w.target = U_LOAD;
      end
      U_ONXT: begin
        w.k_inc  = 1'b1;
        w.cond   = C_GOTO;
        w.target = U_ORD;
      end
      default: begin
        w.cond   = C_GOTO;
        w.target = U_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/text_record_exchange_sorter.sv @@
// ----------------------------------------------------------------------------
// text_record_exchange_sorter: batch exchange sort of text records
// Collects records, sorts them by name or grade key on the last one, and
// streams them back out with their rank.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o  | text_word0..3, text_length,
//          |           |                          | last_record
//  out     | output    | out_valid_o / out_stall_i| rank, out_word0..3,
//          |           |                          | out_length, last_result
//  cfg     | input     | cfg_we_i                 | cfg_wdata_i (sort_order)
//
//  Loading takes one record per cycle. After the last record the sequencer
//  sorts an index table; each compare reads an order entry on the single
//  order-table read port, then its record, then compares. Output then reads
//  an entry and its record per result and holds while downstream stalls.
//  Input is stalled from the last record until the last result is loaded.
//  Reset is asynchronous and clears control state and the mode (name
//  ascending); the record store needs no clearing.
//
module text_record_exchange_sorter
  import tres_pkg::*;
#(
  parameter int unsigned MAX_RECORDS  = 32,
  parameter int unsigned RECORD_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [MODE_W-1:0]   cfg_wdata_i,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [WORD_W-1:0]   text_word0_i,
  input  logic [WORD_W-1:0]   text_word1_i,
  input  logic [WORD_W-1:0]   text_word2_i,
  input  logic [WORD_W-1:0]   text_word3_i,
  input  logic [LEN_W-1:0]    text_length_i,
  input  logic                last_record_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [RANK_W-1:0]   rank_o,
  output logic [WORD_W-1:0]   out_word0_o,
  output logic [WORD_W-1:0]   out_word1_o,
  output logic [WORD_W-1:0]   out_word2_o,
  output logic [WORD_W-1:0]   out_word3_o,
  output logic [LEN_W-1:0]    out_length_o,
  output logic                last_result_o
);

  localparam int unsigned IDX_W = $clog2(MAX_RECORDS);
  localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
  localparam int unsigned REC_W = LEN_W + TEXT_W;
  localparam int unsigned NBYTE = TEXT_W / 8;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_RECORDS);
  localparam logic [LEN_W-1:0] LEN_CLIP = LEN_W'(RECORD_BYTES);

  // --------------------------------------------------------------------------
  // Key helpers
  // --------------------------------------------------------------------------

  function automatic logic [7:0] byte_at(logic [TEXT_W-1:0] t, logic [4:0] p);
    logic [TEXT_W-1:0] sh;
    sh = t << {p, 3'b000};
    return sh[TEXT_W-1 -: 8];
  endfunction

  // Byte-wise compare that stops at the first byte that differs or is zero in
  // both. Each byte pair becomes a greater bit and a less bit (a shared zero
  // counts as less, so it ends the compare as "not greater"); comparing the
  // two bit vectors then gives the answer of the first deciding byte.
  function automatic logic name_gt(logic [TEXT_W-1:0] x, logic [TEXT_W-1:0] y);
    logic [NBYTE-1:0] g;
    logic [NBYTE-1:0] l;
    logic [7:0]       xb;
    logic [7:0]       yb;
    for (int i = 0; i < NBYTE; i++) begin
      xb = x[TEXT_W-1-8*i -: 8];
      yb = y[TEXT_W-1-8*i -: 8];
      g[NBYTE-1-i] = (xb > yb);
      l[NBYTE-1-i] = (xb < yb) || ((xb == 8'd0) && (yb == 8'd0));
    end
    return g > l;
  endfunction

  function automatic logic [15:0] grade_key(logic [TEXT_W-1:0] t, logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] lc;
    logic [LEN_W-1:0] p1;
    logic [LEN_W-1:0] p2;
    logic [7:0]       k0;
    logic [7:0]       k1;
    lc = (len > LEN_CLIP) ? LEN_CLIP : len;
    p1 = lc - LEN_W'(1);
    p2 = lc - LEN_W'(2);
    k0 = (lc >= LEN_W'(2)) ? byte_at(t, p2[4:0]) : 8'd0;
    k1 = (lc >= LEN_W'(1)) ? byte_at(t, p1[4:0]) : 8'd0;
    return {k0, k1};
  endfunction

  function automatic logic grade_gt(logic [15:0] x, logic [15:0] y);
    logic [1:0] g;
    logic [1:0] l;
    for (int i = 0; i < 2; i++) begin
      g[1-i] = (x[15-8*i -: 8] > y[15-8*i -: 8]);
      l[1-i] = (x[15-8*i -: 8] < y[15-8*i -: 8]) ||
               ((x[15-8*i -: 8] == 8'd0) && (y[15-8*i -: 8] == 8'd0));
    end
    return g > l;
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------

  upc_t  upc_q, upc_d;
  ctrl_t ctl;

  assign ctl = ucode(upc_q);

  logic [MODE_W-1:0] mode_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  a_q, a_d;
  logic [IDX_W-1:0]  b_q, b_d;
  logic [IDX_W-1:0]  k_q, k_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers
  logic [IDX_W-1:0]  cur_q;       // index held at position a during a pass
  logic [REC_W-1:0]  rec_a_q;     // record of cur_q
  logic [IDX_W-1:0]  ord_rd_q;    // order table read data
  logic [REC_W-1:0]  rec_rd_q;    // record store read data
  logic [REC_W-1:0]  out_rec_q;
  logic [RANK_W-1:0] out_rank_q;
  logic              out_last_q;

  logic [REC_W-1:0]  rec_mem [MAX_RECORDS];
  logic [IDX_W-1:0]  ord_mem [MAX_RECORDS];

  logic [IDX_W-1:0]  n_last;
  logic              in_acc;
  logic              store_ok;
  logic              out_fire;
  logic              k_last;
  logic              reverse;
  logic              grade_mode;
  logic              greater;
  logic              swap;

  assign n_last     = IDX_W'(cnt_q - CNT_W'(1));
  assign in_stall_o = ~ctl.in_rdy;
  assign in_acc     = in_valid_i & ctl.in_rdy;
  assign store_ok   = cnt_q < CNT_MAX;
  assign out_fire   = ctl.out_ld & (~out_valid_q | ~out_stall_i);
  assign k_last     = (k_q == n_last);
  assign reverse    = (mode_q == SO_NAME_DESC) || (mode_q == SO_GRADE_DESC);
  assign grade_mode = (mode_q == SO_GRADE_ASC) || (mode_q == SO_GRADE_DESC);

  // Key compare of the record at position a against the one at position b
  always_comb begin
    if (grade_mode) begin
      greater = grade_gt(grade_key(rec_a_q[TEXT_W-1:0], rec_a_q[REC_W-1 -: LEN_W]),
                         grade_key(rec_rd_q[TEXT_W-1:0], rec_rd_q[REC_W-1 -: LEN_W]));
    end else begin
      greater = name_gt(rec_a_q[TEXT_W-1:0], rec_rd_q[TEXT_W-1:0]);
    end
  end

  assign swap = ctl.cmp & greater;

  // Next step
  always_comb begin
    upc_d = upc_q;
    unique case (ctl.cond)
      C_NEXT: upc_d = upc_q + UPC_W'(1);
      C_GOTO: upc_d = ctl.target;
      C_IN: begin
        if (in_acc && last_record_i) begin
          upc_d = ctl.target;
        end
      end
      C_AEND: upc_d = (a_q == n_last) ? ctl.target : upc_q + UPC_W'(1);
      C_BEND: upc_d = (b_q == n_last) ? ctl.target : upc_q + UPC_W'(1);
      C_OUT: begin
        if (out_fire) begin
          upc_d = k_last ? ctl.target : upc_q + UPC_W'(1);
        end
      end
      default: upc_d = U_LOAD;
    endcase
  end

  // Counters
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc && store_ok) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (out_fire && k_last) begin
      cnt_d = '0;   // batch done, start empty
    end

    a_d = a_q;
    if (ctl.a_clr) begin
      a_d = '0;
    end else if (ctl.wb) begin
      a_d = a_q + IDX_W'(1);
    end

    b_d = b_q;
    if (ctl.b_init) begin
      b_d = a_q + IDX_W'(1);
    end else if (ctl.cmp) begin
      b_d = b_q + IDX_W'(1);
    end

    k_d = k_q;
    if (ctl.k_clr) begin
      k_d = '0;
    end else if (ctl.k_inc) begin
      k_d = k_q + IDX_W'(1);
    end

    out_valid_d = out_valid_q;
    if (out_fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_LOAD;
      mode_q      <= SO_RESET;
      cnt_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      a_q         <= a_d;
      b_q         <= b_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Record store
  // --------------------------------------------------------------------------

  logic [TEXT_W-1:0] text_mask;
  logic [TEXT_W-1:0] text_in;

  // bytes past the record size are stored as zero
  always_comb begin
    for (int p = 0; p < NBYTE; p++) begin
      text_mask[TEXT_W-1-8*p -: 8] = (p < RECORD_BYTES) ? 8'hFF : 8'h00;
    end
  end

  assign text_in = {text_word0_i, text_word1_i, text_word2_i, text_word3_i} & text_mask;

  always_ff @(posedge clk_i) begin
    if (in_acc && store_ok) begin
      rec_mem[cnt_q[IDX_W-1:0]] <= {text_length_i, text_in};
    end
    if (ctl.rec_re) begin
      rec_rd_q <= rec_mem[ord_rd_q];
    end
  end

  // --------------------------------------------------------------------------
  // Order table: loading writes the identity, the sort permutes it
  // --------------------------------------------------------------------------

  logic             ord_we;
  logic [IDX_W-1:0] ord_waddr;
  logic [IDX_W-1:0] ord_wdata;
  logic [IDX_W-1:0] ord_raddr;

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = cnt_q[IDX_W-1:0];
    ord_wdata = cnt_q[IDX_W-1:0];
    priority if (in_acc && store_ok) begin
      ord_we = 1'b1;
    end else if (swap) begin
      ord_we    = 1'b1;
      ord_waddr = b_q;
      ord_wdata = cur_q;
    end else if (ctl.wb) begin
      ord_we    = 1'b1;
      ord_waddr = a_q;
      ord_wdata = cur_q;
    end else begin
      ord_we = 1'b0;
    end
  end

  always_comb begin
    unique case (ctl.ord_sel)
      OS_A:    ord_raddr = a_q;
      OS_B:    ord_raddr = b_q;
      OS_K:    ord_raddr = reverse ? (n_last - k_q) : k_q;
      default: ord_raddr = a_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (ctl.ord_re) begin
      ord_rd_q <= ord_mem[ord_raddr];
    end
  end

  // Entry at position a: taken from the table, replaced on a swap
  always_ff @(posedge clk_i) begin
    if (ctl.cur_ld || swap) begin
      cur_q <= ord_rd_q;
    end
    if (ctl.lat_a || swap) begin
      rec_a_q <= rec_rd_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_rec_q  <= rec_rd_q;
      out_rank_q <= RANK_W'(k_q) + RANK_W'(1);
      out_last_q <= k_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rank_o        = out_rank_q;
  assign out_word0_o   = out_rec_q[TEXT_W-1 -: WORD_W];
  assign out_word1_o   = out_rec_q[TEXT_W-1-WORD_W -: WORD_W];
  assign out_word2_o   = out_rec_q[TEXT_W-1-2*WORD_W -: WORD_W];
  assign out_word3_o   = out_rec_q[WORD_W-1:0];
  assign out_length_o  = out_rec_q[REC_W-1 -: LEN_W];
  assign last_result_o = out_last_q;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for text_record_exchange_sorter
// Feeds batches of text records through the valid/stall input channel. An
// in-bench exchange sort computes the ranked output of every batch, and each
// result transaction is checked field by field against it. A short directed
// table runs first, then random batches under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import tres_pkg::*;

  localparam int MAX_RECS    = 32;
  localparam int REC_BYTES   = 32;
  localparam int RANDOM_RECS = 250;
  localparam int SETTLE      = 8;       // cycles for the sequencer to fall back to load
  localparam int HOLD_OFF    = 400;     // one long downstream stall
  localparam int LIMIT       = 400000;  // cycle budget for the whole run

  // One stored record: 32 text bytes (byte 0 in the top bits) and its length.
  typedef struct packed {
    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0]  len;
  } rec_t;

  // One ranked output transaction.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0]  len;
    logic              last;
  } ranked_t;

  // Directed stimulus row. When echo is set the batch holds this single
  // record, so the expected result is the record itself at rank 1.
  typedef struct {
    bit              cfg_wr;
    logic [MODE_W-1:0] order;
    rec_t            r;
    bit              last;
    bit              echo;
  } stim_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [MODE_W-1:0]   cfg_wdata_i   = '0;
  logic                in_valid_i    = 1'b0;
  logic                in_stall_o;
  logic [WORD_W-1:0]   text_word0_i  = '0;
  logic [WORD_W-1:0]   text_word1_i  = '0;
  logic [WORD_W-1:0]   text_word2_i  = '0;
  logic [WORD_W-1:0]   text_word3_i  = '0;
  logic [LEN_W-1:0]    text_length_i = '0;
  logic                last_record_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i   = 1'b0;
  logic [RANK_W-1:0]   rank_o;
  logic [WORD_W-1:0]   out_word0_o;
  logic [WORD_W-1:0]   out_word1_o;
  logic [WORD_W-1:0]   out_word2_o;
  logic [WORD_W-1:0]   out_word3_o;
  logic [LEN_W-1:0]    out_length_o;
  logic                last_result_o;

  text_record_exchange_sorter #(
    .MAX_RECORDS  (MAX_RECS),
    .RECORD_BYTES (REC_BYTES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_word0_i  (text_word0_i),
    .text_word1_i  (text_word1_i),
    .text_word2_i  (text_word2_i),
    .text_word3_i  (text_word3_i),
    .text_length_i (text_length_i),
    .last_record_i (last_record_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rank_o        (rank_o),
    .out_word0_o   (out_word0_o),
    .out_word1_o   (out_word1_o),
    .out_word2_o   (out_word2_o),
    .out_word3_o   (out_word3_o),
    .out_length_o  (out_length_o),
    .last_result_o (last_result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sort predictor: its own copy of the record store, count and sort order
  // ---------------------------------------------------------------------------
  rec_t              held_recs [MAX_RECS];
  int                held_count  = 0;
  logic [MODE_W-1:0] sort_mode   = SO_RESET;
  ranked_t           batch_out [$];   // ranked output of the latest batch
  ranked_t           ranked_q [$];    // results still owed by the block

  int       mismatches   = 0;
  int       results_seen = 0;
  int       records_sent = 0;
  int       batches      = 0;
  bit [3:0] orders_used  = '0;
  int       burst_left   = 0;
  bit       random_on    = 1'b0;
  bit       held_off     = 1'b0;
  int       cycles       = 0;

  function automatic logic [7:0] char_at(rec_t r, int pos);
    if (pos < 0 || pos >= REC_BYTES) return 8'h00;
    return r.text[TEXT_W-1-8*pos -: 8];
  endfunction

  // Key of record a strictly above key of record b under the current order.
  // Both keys are scanned byte by byte; a zero byte common to both ends it.
  function automatic bit key_above(rec_t a, rec_t b);
    logic [7:0] ca, cb;
    logic [7:0] ga [2];
    logic [7:0] gb [2];
    int la, lb, i;
    if (sort_mode == SO_NAME_DESC || sort_mode == SO_NAME_ASC) begin
      for (i = 0; i < REC_BYTES; i++) begin
        ca = char_at(a, i);
        cb = char_at(b, i);
        if (ca != cb) return ca > cb;
        if (ca == 8'h00) return 1'b0;
      end
      return 1'b0;
    end
    // grade key: the two characters ending at the clamped length
    la = (int'(a.len) > REC_BYTES) ? REC_BYTES : int'(a.len);
    lb = (int'(b.len) > REC_BYTES) ? REC_BYTES : int'(b.len);
    for (i = 0; i < 2; i++) begin
      ga[i] = char_at(a, la - 2 + i);
      gb[i] = char_at(b, lb - 2 + i);
    end
    for (i = 0; i < 2; i++) begin
      if (ga[i] != gb[i]) return ga[i] > gb[i];
      if (ga[i] == 8'h00) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Store one accepted record; on the last one sort and rank the batch.
  function automatic void take_record(rec_t r, bit last);
    int order [MAX_RECS];
    int n, a, b, k, t;
    bit rev;
    ranked_t res;
    if (held_count < MAX_RECS) begin
      held_recs[held_count] = r;
      held_count++;
    end
    batch_out.delete();
    if (!last) return;
    n = held_count;
    for (k = 0; k < n; k++) order[k] = k;
    for (a = 0; a < n; a++) begin
      for (b = a; b < n; b++) begin
        if (key_above(held_recs[order[a]], held_recs[order[b]])) begin
          t        = order[a];
          order[a] = order[b];
          order[b] = t;
        end
      end
    end
    rev = (sort_mode == SO_NAME_DESC || sort_mode == SO_GRADE_DESC);
    for (k = 0; k < n; k++) begin
      res.rank = RANK_W'(k + 1);
      res.text = held_recs[order[rev ? n - 1 - k : k]].text;
      res.len  = held_recs[order[rev ? n - 1 - k : k]].len;
      res.last = (k == n - 1);
      batch_out.push_back(res);
    end
    orders_used[sort_mode] = 1'b1;
    batches++;
    held_count = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Record builders
  // ---------------------------------------------------------------------------
  function automatic rec_t rec_of(logic [TEXT_W-1:0] t, logic [LEN_W-1:0] l);
    rec_t r;
    r.text = t;
    r.len  = l;
    return r;
  endfunction

  function automatic rec_t txt(string s, int l);
    logic [TEXT_W-1:0] t;
    int i;
    t = '0;
    for (i = 0; i < s.len() && i < REC_BYTES; i++) t[TEXT_W-1-8*i -: 8] = s[i];
    return rec_of(t, LEN_W'(l));
  endfunction

  // Mostly well-formed names over a narrow alphabet (plenty of ties), some
  // with arbitrary bytes, some with stray zeros and a wrong length, some
  // fully random.
  function automatic rec_t make_rec();
    logic [TEXT_W-1:0] t;
    int kind, l, i;
    t    = '0;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      l = (kind == 5 || kind == 7) ? $urandom_range(0, REC_BYTES) : $urandom_range(0, 10);
      for (i = 0; i < l; i++) begin
        if (kind >= 6)
          t[TEXT_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
        else if (i >= l - 2)
          t[TEXT_W-1-8*i -: 8] = 8'h41 + 8'($urandom_range(0, 2));
        else
          t[TEXT_W-1-8*i -: 8] = 8'h41 + 8'($urandom_range(0, 3));
      end
      return rec_of(t, LEN_W'(l));
    end
    if (kind == 8) begin
      l = $urandom_range(0, REC_BYTES);
      for (i = 0; i < l; i++) t[TEXT_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
      return rec_of(t, LEN_W'($urandom_range(0, 63)));
    end
    for (i = 0; i < TEXT_W / 32; i++) t[32*i +: 32] = $urandom;
    return rec_of(t, LEN_W'($urandom_range(0, 63)));
  endfunction

  function automatic stim_row_t row(bit cfg_wr, logic [MODE_W-1:0] order, rec_t r,
                                    bit last, bit echo);
    stim_row_t s;
    s.cfg_wr = cfg_wr;
    s.order  = order;
    s.r      = r;
    s.last   = last;
    s.echo   = echo;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one record and hold it until the block takes it. Bursts of random
  // length alternate with random gaps; now and then a long gap-free burst.
  task automatic send(input rec_t r, input bit last, input bit echo);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(30, 80);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    text_word0_i  <= r.text[255:192];
    text_word1_i  <= r.text[191:128];
    text_word2_i  <= r.text[127:64];
    text_word3_i  <= r.text[63:0];
    text_length_i <= r.len;
    last_record_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    records_sent++;
    take_record(r, last);
    if (last) begin
      if (echo)
        ranked_q.push_back(ranked_t'{rank: RANK_W'(1), text: r.text, len: r.len, last: 1'b1});
      else
        foreach (batch_out[k]) ranked_q.push_back(batch_out[k]);
    end
  endtask

  // Change the sort order only once the block has drained and gone idle.
  task automatic set_order(input logic [MODE_W-1:0] mode);
    in_valid_i <= 1'b0;
    while (ranked_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sort_mode    = mode;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern, with one long hold-off once random batches
  // run, so the next batch piles up against a stalled input.
  // ---------------------------------------------------------------------------
  initial begin : stall_drive
    int seg, pct;
    forever begin
      seg = $urandom_range(5, 60);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 30;
        2:       pct = 60;
        default: pct = 90;
      endcase
      repeat (seg) begin
        if (random_on && !held_off && out_valid_o && ranked_q.size() > 3) begin
          out_stall_i <= 1'b1;
          repeat (HOLD_OFF) @(posedge clk_i);
          held_off = 1'b1;
        end
        out_stall_i <= ($urandom_range(0, 99) < pct);
        @(posedge clk_i);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    ranked_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (ranked_q.size() == 0) begin
        $error("result with rank %0d arrived with none expected", rank_o);
        mismatches++;
      end else begin
        want = ranked_q.pop_front();
        check_field("rank",        64'(want.rank),          64'(rank_o));
        check_field("out_word0",   want.text[255:192],      out_word0_o);
        check_field("out_word1",   want.text[191:128],      out_word1_o);
        check_field("out_word2",   want.text[127:64],       out_word2_o);
        check_field("out_word3",   want.text[63:0],         out_word3_o);
        check_field("out_length",  64'(want.len),           64'(out_length_o));
        check_field("last_result", 64'(want.last),          64'(last_result_o));
        results_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t rows [$];
    int j, bsize, random_sent;
    bit first;

    // reset order, name ascending: empty record and all-ones extreme alone
    rows.push_back(row(0, SO_NAME_ASC, rec_of('0, 6'd0), 1, 1));
    rows.push_back(row(0, SO_NAME_ASC, rec_of('1, 6'd63), 1, 1));
    // names with a tie, a prefix, a high byte and zeros inside the text
    rows.push_back(row(0, SO_NAME_ASC, txt("CAROL", 5), 0, 0));
    rows.push_back(row(0, SO_NAME_ASC, txt("ALICE", 5), 0, 0));
    rows.push_back(row(0, SO_NAME_ASC, txt("BOB", 3), 0, 0));
    rows.push_back(row(0, SO_NAME_ASC, txt("ALICE", 5), 0, 0));
    rows.push_back(row(0, SO_NAME_ASC, txt("AL", 2), 0, 0));
    rows.push_back(row(0, SO_NAME_ASC, rec_of({8'hFF, 8'h41, 240'h0}, 6'd2), 0, 0));
    rows.push_back(row(0, SO_NAME_ASC, rec_of({8'h41, 8'h00, 8'h43, 232'h0}, 6'd3), 0, 0));
    rows.push_back(row(0, SO_NAME_ASC, rec_of({8'h41, 8'h00, 8'h42, 232'h0}, 6'd3), 1, 0));
    // name descending with ties
    rows.push_back(row(1, SO_NAME_DESC, txt("DAN", 3), 0, 0));
    rows.push_back(row(0, SO_NAME_DESC, txt("EVE", 3), 0, 0));
    rows.push_back(row(0, SO_NAME_DESC, txt("DAN", 3), 1, 0));
    // grade ascending: short records, empty record, length past the store
    rows.push_back(row(1, SO_GRADE_ASC, txt("ANN BA", 6), 0, 0));
    rows.push_back(row(0, SO_GRADE_ASC, txt("TOM AA", 6), 0, 0));
    rows.push_back(row(0, SO_GRADE_ASC, txt("X", 1), 0, 0));
    rows.push_back(row(0, SO_GRADE_ASC, txt("", 0), 0, 0));
    rows.push_back(row(0, SO_GRADE_ASC, txt("ABCDEFGHIJKLMNOPQRSTUVWXYZ0123AA", 40), 0, 0));
    rows.push_back(row(0, SO_GRADE_ASC, txt("ZED CB", 6), 1, 0));
    // grade descending with a tie
    rows.push_back(row(1, SO_GRADE_DESC, txt("P AA", 4), 0, 0));
    rows.push_back(row(0, SO_GRADE_DESC, txt("Q AA", 4), 0, 0));
    rows.push_back(row(0, SO_GRADE_DESC, txt("R BB", 4), 0, 0));
    rows.push_back(row(0, SO_GRADE_DESC, txt("CC", 2), 1, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].cfg_wr) set_order(rows[i].order);
      send(rows[i].r, rows[i].last, rows[i].echo);
    end

    // Random batches. The first one overruns the store so records get
    // dropped, and the long output hold-off lands on it.
    random_on   = 1'b1;
    random_sent = 0;
    first       = 1'b1;
    bsize       = 36;
    while (random_sent < RANDOM_RECS) begin
      for (j = 0; j < bsize; j++) begin
        send(make_rec(), j == bsize - 1, 1'b0);
        random_sent++;
      end
      if (!first && $urandom_range(0, 2) == 0) set_order(MODE_W'($urandom_range(0, 3)));
      first = 1'b0;
      bsize = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    in_valid_i <= 1'b0;

    while (ranked_q.size() != 0) @(posedge clk_i);
    repeat (4 * SETTLE) @(posedge clk_i);

    $display("Sent %0d records in %0d sorted batches; %0d ranked results checked.",
             records_sent, batches, results_seen);
    $display("Sort orders exercised (bit per order): %b, store overrun included.", orders_used);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ text_record_exchange_sorter.f @@
hw/rtl/tres_pkg.sv
hw/rtl/text_record_exchange_sorter.sv
verif/tb.sv
